[rtl/wes_pkg.sv]
package wes_pkg;

    // Sample format and grid limits
    localparam int SAMPLE_BITS = 32;
    localparam int FRAC_BITS   = 28;
    localparam int MAX_WIDTH   = 2048;
    localparam int MAX_HEIGHT  = 4096;
    localparam int MIN_DIM     = 3;

    localparam int COL_BITS    = $clog2(MAX_WIDTH);
    localparam int ROW_BITS    = $clog2(MAX_HEIGHT);
    localparam int WIDTH_BITS  = COL_BITS + 1;
    localparam int HEIGHT_BITS = ROW_BITS + 1;
    localparam int FACTOR_BITS = FRAC_BITS + 1;

    // Datapath widths
    localparam int LAP_BITS   = SAMPLE_BITS + 4;
    localparam int BASE_BITS  = SAMPLE_BITS + 2;
    localparam int SPLIT_BITS = LAP_BITS / 2;
    localparam int HI_BITS    = LAP_BITS - SPLIT_BITS;
    localparam int PLO_BITS   = FACTOR_BITS + SPLIT_BITS;
    localparam int PHI_BITS   = FACTOR_BITS + 1 + HI_BITS;
    localparam int PROD_BITS  = 2 * SAMPLE_BITS;
    localparam int TERM_BITS  = PROD_BITS - FRAC_BITS;
    localparam int RES_BITS   = TERM_BITS + 1;

    // Queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);

    // Configuration register indexes
    localparam logic [1:0] CFG_FACTOR = 2'd0;
    localparam logic [1:0] CFG_WIDTH  = 2'd1;
    localparam logic [1:0] CFG_HEIGHT = 2'd2;

    // Configuration reset values
    localparam logic [FACTOR_BITS-1:0] FACTOR_RESET = FACTOR_BITS'(67108864);
    localparam logic [WIDTH_BITS-1:0]  WIDTH_RESET  = WIDTH_BITS'(2048);
    localparam logic [HEIGHT_BITS-1:0] HEIGHT_RESET = HEIGHT_BITS'(2048);

    localparam logic [FACTOR_BITS-1:0] FACTOR_ONE = FACTOR_BITS'(1) << FRAC_BITS;

    typedef struct packed {
        logic [FACTOR_BITS-1:0] factor;
        logic [WIDTH_BITS-1:0]  width;
        logic [HEIGHT_BITS-1:0] height;
    } t_cfg;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] curr_height;
        logic signed [SAMPLE_BITS-1:0] prev_height;
    } t_in_item;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] next_height;
        logic [ROW_BITS-1:0]           out_row;
        logic [COL_BITS-1:0]           out_col;
        logic                          grid_last;
    } t_out_item;

    // Classified cell handed from front to back
    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] cur;
        logic signed [SAMPLE_BITS-1:0] prv;
        logic [COL_BITS-1:0]           col;
        logic [ROW_BITS-1:0]           row;
        logic                          has_upper;
        logic                          interior;
        logic                          last_row;
        logic                          last_col;
    } t_cell;

endpackage

[rtl/wes_front.sv]
module wes_front
    import wes_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_cfg     i_cfg,
    input  logic     i_valid,
    output logic     o_stall,
    input  t_in_item i_data,
    input  logic     i_full,
    output logic     o_push,
    output t_cell    o_cell
);

    localparam logic [WIDTH_BITS-1:0]  W_MIN = WIDTH_BITS'(MIN_DIM);
    localparam logic [WIDTH_BITS-1:0]  W_MAX = WIDTH_BITS'(MAX_WIDTH);
    localparam logic [HEIGHT_BITS-1:0] H_MIN = HEIGHT_BITS'(MIN_DIM);
    localparam logic [HEIGHT_BITS-1:0] H_MAX = HEIGHT_BITS'(MAX_HEIGHT);

    logic [COL_BITS-1:0]    r_col, n_col;
    logic [ROW_BITS-1:0]    r_row, n_row;
    logic [WIDTH_BITS-1:0]  w_eff;
    logic [HEIGHT_BITS-1:0] h_eff;
    logic                   last_col;
    logic                   last_row;

    // Clamp grid size into its working range
    always_comb begin
        priority if (i_cfg.width < W_MIN) begin
            w_eff = W_MIN;
        end else if (i_cfg.width > W_MAX) begin
            w_eff = W_MAX;
        end else begin
            w_eff = i_cfg.width;
        end
        priority if (i_cfg.height < H_MIN) begin
            h_eff = H_MIN;
        end else if (i_cfg.height > H_MAX) begin
            h_eff = H_MAX;
        end else begin
            h_eff = i_cfg.height;
        end
    end

    assign last_col = WIDTH_BITS'(r_col) >= (w_eff - WIDTH_BITS'(1));
    assign last_row = HEIGHT_BITS'(r_row) >= (h_eff - HEIGHT_BITS'(1));

    assign o_stall = i_full;
    assign o_push  = i_valid && !i_full;

    // Classify the cell at the raster position
    always_comb begin
        o_cell.cur       = i_data.curr_height;
        o_cell.prv       = i_data.prev_height;
        o_cell.col       = r_col;
        o_cell.row       = r_row;
        o_cell.has_upper = (r_row != '0);
        o_cell.interior  = (r_row >= ROW_BITS'(2)) && (r_col != '0) && !last_col;
        o_cell.last_row  = last_row;
        o_cell.last_col  = last_col;
    end

    // Advance the raster position
    always_comb begin
        n_col = r_col;
        n_row = r_row;
        if (o_push) begin
            if (last_col) begin
                n_col = '0;
                n_row = last_row ? '0 : r_row + ROW_BITS'(1);
            end else begin
                n_col = r_col + COL_BITS'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

endmodule

[rtl/wes_queue.sv]
module wes_queue
    import wes_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_cell i_cell,
    output logic  o_full,
    input  logic  i_pop,
    output logic  o_empty,
    output t_cell o_head
);

    t_cell                r_mem [QUEUE_DEPTH];
    logic [QPTR_BITS-1:0] r_wr_ptr;
    logic [QPTR_BITS-1:0] r_rd_ptr;
    logic [QPTR_BITS:0]   r_count;
    logic                 do_push;
    logic                 do_pop;

    assign o_full  = (r_count == (QPTR_BITS+1)'(QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_head  = r_mem[r_rd_ptr];

    // Store the pushed cell
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_cell;
        end
    end

    // Track pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + QPTR_BITS'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + QPTR_BITS'(1);
            end
            unique case ({do_push, do_pop})
                2'b10:   r_count <= r_count + (QPTR_BITS+1)'(1);
                2'b01:   r_count <= r_count - (QPTR_BITS+1)'(1);
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

[rtl/wes_back.sv]
module wes_back
    import wes_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cfg      i_cfg,
    input  logic      i_empty,
    input  t_cell     i_head,
    output logic      o_pop,
    output logic      o_valid,
    input  logic      i_stall,
    output t_out_item o_data
);

    localparam logic signed [SAMPLE_BITS-1:0] SAT_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    localparam logic signed [SAMPLE_BITS-1:0] SAT_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
    localparam logic [PROD_BITS-1:0]          ROUND_HALF = PROD_BITS'(1) << (FRAC_BITS - 1);

    // Row stores
    logic signed [SAMPLE_BITS-1:0] mem_newer [MAX_WIDTH];
    logic signed [SAMPLE_BITS-1:0] mem_older [MAX_WIDTH];
    logic signed [SAMPLE_BITS-1:0] mem_dprev [MAX_WIDTH];

    logic                en;
    logic [COL_BITS-1:0] rd_right_addr;

    // Stage 1: row store read data
    logic                          r_s1_v;
    t_cell                         r_s1;
    logic signed [SAMPLE_BITS-1:0] r_rd_ctr;
    logic signed [SAMPLE_BITS-1:0] r_rd_right;
    logic signed [SAMPLE_BITS-1:0] r_rd_up;
    logic signed [SAMPLE_BITS-1:0] r_rd_dprev;
    logic signed [SAMPLE_BITS-1:0] r_left;
    logic signed [LAP_BITS-1:0]    lap;
    logic signed [BASE_BITS-1:0]   base;

    // Stage 2: Laplacian and base
    logic                        r_s2_v;
    t_cell                       r_s2;
    logic signed [LAP_BITS-1:0]  r_s2_lap;
    logic signed [BASE_BITS-1:0] r_s2_base;
    logic [FACTOR_BITS-1:0]      f_eff;
    logic [SPLIT_BITS-1:0]       lap_lo;
    logic signed [HI_BITS-1:0]   lap_hi;
    logic [PLO_BITS-1:0]         p_lo;
    logic signed [PHI_BITS-1:0]  p_hi;

    // Stage 3: partial products
    logic                        r_s3_v;
    t_cell                       r_s3;
    logic [PLO_BITS-1:0]         r_s3_plo;
    logic signed [PHI_BITS-1:0]  r_s3_phi;
    logic signed [BASE_BITS-1:0] r_s3_base;
    logic [PROD_BITS-1:0]        prod_sum;

    // Stage 4: rounded term
    logic                        r_s4_v;
    t_cell                       r_s4;
    logic signed [TERM_BITS-1:0] r_s4_term;
    logic signed [BASE_BITS-1:0] r_s4_base;
    logic signed [RES_BITS-1:0]  res_wide;
    logic signed [SAMPLE_BITS-1:0] res_sat;

    // Output register with a second result waiting behind it
    logic                r_o_valid;
    t_out_item           r_o_data;
    logic                r_pend;
    logic [ROW_BITS-1:0] r_b_row;
    logic [COL_BITS-1:0] r_b_col;
    logic                r_b_last;

    // Whole pipeline moves when the output register can take a new cell
    assign en    = !r_o_valid || (!i_stall && !r_pend);
    assign o_pop = en && !i_empty;

    assign rd_right_addr = i_head.col + COL_BITS'(1);

    // Read the row stores for the popped cell
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s1       <= i_head;
            r_rd_ctr   <= mem_newer[i_head.col];
            r_rd_right <= mem_newer[rd_right_addr];
            r_rd_up    <= mem_older[i_head.col];
            r_rd_dprev <= mem_dprev[i_head.col];
        end
    end

    // Rotate the row stores at the cell's column
    always_ff @(posedge i_clk) begin
        if (en && r_s1_v) begin
            mem_older[r_s1.col] <= r_rd_ctr;
            mem_newer[r_s1.col] <= r_s1.cur;
            mem_dprev[r_s1.col] <= r_s1.prv;
        end
    end

    // Keep the previous center as the left neighbor
    always_ff @(posedge i_clk) begin
        if (en && r_s1_v) begin
            r_left <= r_rd_ctr;
        end
    end

    // Five-point Laplacian and 2*curr - prev
    always_comb begin
        lap = LAP_BITS'(r_rd_up) + LAP_BITS'(r_s1.cur) + LAP_BITS'(r_left)
            + LAP_BITS'(r_rd_right) - (LAP_BITS'(r_rd_ctr) <<< 2);
        base = (BASE_BITS'(r_rd_ctr) <<< 1) - BASE_BITS'(r_rd_dprev);
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s2      <= r_s1;
            r_s2_lap  <= lap;
            r_s2_base <= base;
        end
    end

    // Clip the factor to one and split the multiply in two halves
    always_comb begin
        f_eff  = (i_cfg.factor > FACTOR_ONE) ? FACTOR_ONE : i_cfg.factor;
        lap_lo = r_s2_lap[SPLIT_BITS-1:0];
        lap_hi = r_s2_lap[LAP_BITS-1:SPLIT_BITS];
        p_lo   = {{SPLIT_BITS{1'b0}}, f_eff} * {{FACTOR_BITS{1'b0}}, lap_lo};
        p_hi   = $signed({{(PHI_BITS-FACTOR_BITS){1'b0}}, f_eff})
               * $signed({{(PHI_BITS-HI_BITS){lap_hi[HI_BITS-1]}}, lap_hi});
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s3      <= r_s2;
            r_s3_plo  <= p_lo;
            r_s3_phi  <= p_hi;
            r_s3_base <= r_s2_base;
        end
    end

    // Join the partial products and round half up
    assign prod_sum = (PROD_BITS'(r_s3_phi) <<< SPLIT_BITS) + PROD_BITS'(r_s3_plo) + ROUND_HALF;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s4      <= r_s3;
            r_s4_term <= $signed(prod_sum[PROD_BITS-1:FRAC_BITS]);
            r_s4_base <= r_s3_base;
        end
    end

    // Add the term and saturate; border cells give zero
    always_comb begin
        res_wide = RES_BITS'(r_s4_base) + RES_BITS'(r_s4_term);
        if (!r_s4.interior) begin
            res_sat = '0;
        end else if (res_wide > RES_BITS'(SAT_MAX)) begin
            res_sat = SAT_MAX;
        end else if (res_wide < RES_BITS'(SAT_MIN)) begin
            res_sat = SAT_MIN;
        end else begin
            res_sat = res_wide[SAMPLE_BITS-1:0];
        end
    end

    // Stage valids
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
            r_s2_v <= 1'b0;
            r_s3_v <= 1'b0;
            r_s4_v <= 1'b0;
        end else if (en) begin
            r_s1_v <= !i_empty;
            r_s2_v <= r_s1_v;
            r_s3_v <= r_s2_v;
            r_s4_v <= r_s3_v;
        end
    end

    // Load the output register: upper row first, then the last row's own cell
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
            r_pend    <= 1'b0;
        end else if (r_o_valid && !i_stall && r_pend) begin
            r_o_valid <= 1'b1;
            r_pend    <= 1'b0;
        end else if (en) begin
            r_o_valid <= r_s4_v && (r_s4.has_upper || r_s4.last_row);
            r_pend    <= r_s4_v && r_s4.has_upper && r_s4.last_row;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_o_valid && !i_stall && r_pend) begin
            r_o_data.next_height <= '0;
            r_o_data.out_row     <= r_b_row;
            r_o_data.out_col     <= r_b_col;
            r_o_data.grid_last   <= r_b_last;
        end else if (en && r_s4_v) begin
            r_b_row  <= r_s4.row;
            r_b_col  <= r_s4.col;
            r_b_last <= r_s4.last_col;
            if (r_s4.has_upper) begin
                r_o_data.next_height <= res_sat;
                r_o_data.out_row     <= r_s4.row - ROW_BITS'(1);
                r_o_data.out_col     <= r_s4.col;
                r_o_data.grid_last   <= 1'b0;
            end else begin
                r_o_data.next_height <= '0;
                r_o_data.out_row     <= r_s4.row;
                r_o_data.out_col     <= r_s4.col;
                r_o_data.grid_last   <= r_s4.last_col;
            end
        end
    end

    assign o_valid = r_o_valid;
    assign o_data  = r_o_data;

endmodule

[rtl/wave_equation_stencil_step_unit.sv]
// One time step of the 2D wave equation over a grid streamed in raster order,
// one cell (current and previous height, signed Q3.28) per transaction. The
// result for row y-1 leaves while row y comes in; on the last row each cell
// also gives its own zero result, so a last-row cell gives two results.
// Elsewhere the unit takes one cell per clock while the output is not
// stalled, bounded by the single output register and by one pass through
// the row stores per cell. A taken cell passes through the queue, the
// back's stage registers and the output register; a four-entry queue
// between the classifying front and the arithmetic back absorbs short output
// stalls. Border cells give zero, results saturate to 32 bits. The row stores
// are not cleared after reset (no clearing pass); the first two rows of a
// grid fill them before any interior cell reads them. Write configuration
// only while the unit is idle.
module wave_equation_stencil_step_unit
    import wes_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    output logic                   o_stall,
    input  t_in_item               i_data,
    output logic                   o_valid,
    input  logic                   i_stall,
    output t_out_item              o_data,
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [1:0]             i_cfg_index,
    input  logic [FACTOR_BITS-1:0] i_cfg_data
);

    t_cfg  r_cfg;
    logic  push;
    logic  full;
    logic  empty;
    logic  pop;
    t_cell push_cell;
    t_cell head_cell;

    assign o_cfg_ready = 1'b1;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.factor <= FACTOR_RESET;
            r_cfg.width  <= WIDTH_RESET;
            r_cfg.height <= HEIGHT_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_FACTOR: r_cfg.factor <= i_cfg_data;
                CFG_WIDTH:  r_cfg.width  <= i_cfg_data[WIDTH_BITS-1:0];
                CFG_HEIGHT: r_cfg.height <= i_cfg_data[HEIGHT_BITS-1:0];
                default:    r_cfg        <= r_cfg;
            endcase
        end
    end

    wes_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_data  (i_data),
        .i_full  (full),
        .o_push  (push),
        .o_cell  (push_cell)
    );

    wes_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cell  (push_cell),
        .o_full  (full),
        .i_pop   (pop),
        .o_empty (empty),
        .o_head  (head_cell)
    );

    wes_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_empty (empty),
        .i_head  (head_cell),
        .o_pop   (pop),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_data  (o_data)
    );

endmodule

[rtl/wes_checker.sv]
module wes_checker
    import wes_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      o_stall,
    input logic      o_valid,
    input logic      i_stall,
    input t_out_item o_data
);

    // Hold a stalled output transaction
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_data))
        else $error("stalled output transaction changed");

    // Drop output valid out of reset
    assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid after reset");

    // Release the input stall out of reset
    assert property (@(posedge i_clk)
        !i_rst_n |=> !o_stall)
        else $error("input stalled after reset");

    // The closing cell of a grid is a border cell and carries zero
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_data.grid_last |-> o_data.next_height == '0)
        else $error("grid end carries a nonzero height");

    // The closing cell sits at least two rows and columns in
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_data.grid_last |-> o_data.out_row >= ROW_BITS'(2)
            && o_data.out_col >= COL_BITS'(2))
        else $error("grid end at an impossible position");

endmodule

bind wave_equation_stencil_step_unit wes_checker u_wes_checker (.*);
